// ----- sv/utf8_sanitizing_copy_macros.svh -----
// assertion helpers for the utf8 copy checker
`ifndef UTF8_SANITIZING_COPY_MACROS_SVH
`define UTF8_SANITIZING_COPY_MACROS_SVH

// same-cycle implication, idle during reset
`define UTF8SC_ASSERT_NOW(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// next-cycle implication, idle during reset
`define UTF8SC_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

// ----- sv/utf8sc_pkg.sv -----
package utf8sc_pkg;

  localparam int CAP_W = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  localparam logic [20:0] MAX_CODEPOINT = 21'h10FFFF;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] LOW6_MASK  = 8'h3F;
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] LEAD4_BITS = 8'h07;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD2_MARK = 8'hC0;
  localparam logic [7:0] LEAD3_MARK = 8'hE0;
  localparam logic [7:0] LEAD4_MARK = 8'hF0;

  // bytes produced by one source byte: up to four encoded bytes, then the terminator
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            term;
  } grp_t;

endpackage

// ----- sv/utf8_sanitizing_copy.sv -----
// channel   | dir | tdata            | tlast          | tuser
// ----------+-----+------------------+----------------+------
// s_axis    | in  | [7:0] src_byte   | end_of_source  | -
// m_axis    | out | [7:0] out_byte   | is_last        | -
// cfg       | in  | cfg_wdata = dest_capacity, written when cfg_we is high
//
// a source beat is taken in any cycle the result register is empty or sends its final beat
// each source beat yields 0 to 5 output beats, sent one per cycle while m_tready is high, from the next cycle on
// a source beat that yields output beats holds the input until the last of them is sent
// rst is synchronous: capacity returns to 256 and the string state clears
// output stalls hold the result register and the input behind it
module utf8_sanitizing_copy (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] src_byte
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] out_byte
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [utf8sc_pkg::CAP_W-1:0]  cfg_wdata
);
  import utf8sc_pkg::*;

  logic fire;
  logic load;
  grp_t grp;

  assign fire = s_tvalid && s_tready;
  // only beats that produce output occupy the result register
  assign load = fire && (grp.cnt != 3'd0 || grp.term);

  utf8sc_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .src_byte  (s_tdata),
    .eos       (s_tlast),
    .grp       (grp)
  );

  utf8sc_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .grp      (grp),
    .in_ready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- sv/utf8sc_decode.sv -----
module utf8sc_decode (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [utf8sc_pkg::CAP_W-1:0] cfg_wdata,
  input  logic                      fire,
  input  logic [7:0]                src_byte,
  input  logic                      eos,
  output utf8sc_pkg::grp_t          grp
);
  import utf8sc_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic [20:0]      acc, acc_next;
  logic [2:0]       slen, slen_next;
  logic [2:0]       got, got_next;
  logic [CAP_W-1:0] wcount, wcount_next;
  logic             stopped, stopped_next;

  logic [2:0]       len;
  logic [20:0]      cp;
  logic [2:0]       cp_len;
  logic [3:0][7:0]  enc;
  logic             fail;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    priority if (b[7] == 1'b0)                 lead_len = 3'd1;
    else if ((b & LEAD2_MASK) == LEAD2_MARK)   lead_len = 3'd2;
    else if ((b & LEAD3_MASK) == LEAD3_MARK)   lead_len = 3'd3;
    else if ((b & LEAD4_MASK) == LEAD4_MARK)   lead_len = 3'd4;
    else                                       lead_len = 3'd0;
  endfunction

  assign len = lead_len(src_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      slen    <= '0;
      got     <= '0;
      wcount  <= '0;
      stopped <= 1'b0;
    end else if (fire) begin
      acc     <= acc_next;
      slen    <= slen_next;
      got     <= got_next;
      wcount  <= wcount_next;
      stopped <= stopped_next;
    end
  end

  // codepoint gathered with this beat
  always_comb begin
    if (slen == 3'd0) begin
      unique case (len)
        3'd1:    cp = {13'd0, src_byte};
        3'd2:    cp = {13'd0, src_byte & LEAD2_BITS};
        3'd3:    cp = {13'd0, src_byte & LEAD3_BITS};
        default: cp = {13'd0, src_byte & LEAD4_BITS};
      endcase
    end else begin
      cp = {acc[14:0], src_byte[5:0]};
    end
  end

  // shortest encoding of the collected codepoint
  always_comb begin
    enc = '0;
    priority if (cp < 21'h80) begin
      cp_len = 3'd1;
      enc[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      cp_len = 3'd2;
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      cp_len = 3'd3;
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
    end else begin
      cp_len = 3'd4;
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
    end
  end

  always_comb begin
    acc_next     = acc;
    slen_next    = slen;
    got_next     = got;
    wcount_next  = wcount;
    stopped_next = stopped;
    fail         = 1'b0;
    grp          = '0;

    if (stopped) begin
      if (eos) begin
        acc_next     = '0;
        slen_next    = '0;
        got_next     = '0;
        wcount_next  = '0;
        stopped_next = 1'b0;
      end
    end else begin
      if (slen == 3'd0) begin
        if (len == 3'd0) begin
          fail = 1'b1;
        end else begin
          slen_next = len;
          got_next  = 3'd1;
          acc_next  = cp;
        end
      end else if ((src_byte & CONT_MASK) != CONT_MARK) begin
        fail = 1'b1;
      end else begin
        acc_next = cp;
        got_next = got + 3'd1;
      end

      if (!fail) begin
        if (got_next < slen_next) begin
          // incomplete sequence; cut off if the source ends here
          fail = eos;
        end else if (cp == '0 || cp > MAX_CODEPOINT) begin
          fail = 1'b1;
        end else if ({1'b0, capacity} <= ({1'b0, wcount} + (CAP_W+1)'(slen_next))) begin
          fail = 1'b1;
        end else begin
          grp.bytes   = enc;
          grp.cnt     = cp_len;
          wcount_next = wcount + CAP_W'(cp_len);
          acc_next    = '0;
          slen_next   = '0;
          got_next    = '0;
          fail        = eos;
        end
      end

      if (fail) begin
        grp.term     = 1'b1;
        acc_next     = '0;
        slen_next    = '0;
        got_next     = '0;
        wcount_next  = '0;
        stopped_next = !eos;
      end
    end
  end

endmodule

// ----- sv/utf8sc_emit.sv -----
module utf8sc_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  utf8sc_pkg::grp_t grp,
  output logic             in_ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast
);
  import utf8sc_pkg::*;

  grp_t       grp_q;
  logic       full;
  logic [2:0] idx;
  logic [2:0] total;
  logic       last_beat;
  logic       pop;

  assign total     = grp_q.cnt + {2'b00, grp_q.term};
  assign last_beat = (idx == total - 3'd1);
  assign pop       = full && m_tready && last_beat;
  assign in_ready  = !full || pop;

  assign m_tvalid = full;
  assign m_tdata  = (idx < grp_q.cnt) ? grp_q.bytes[idx[1:0]] : 8'h00;
  assign m_tlast  = grp_q.term && last_beat;

  always_ff @(posedge clk) begin
    if (load) begin
      grp_q <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      full <= 1'b1;
      idx  <= '0;
    end else if (full && m_tready) begin
      if (last_beat) begin
        full <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

endmodule

// ----- sv/utf8sc_checker.sv -----
`include "utf8_sanitizing_copy_macros.svh"

module utf8sc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // terminator beat is always a zero byte
  `UTF8SC_ASSERT_NOW(a_term_zero, m_tvalid && m_tlast, m_tdata == 8'h00, "terminator not zero")

  // an empty output side never blocks input
  `UTF8SC_ASSERT_NOW(a_ready_idle, !m_tvalid, s_tready, "input blocked with no pending output")

  // a stalled output beat holds
  `UTF8SC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed under stall")

  // input is only taken when the pending output finishes or there is none
  `UTF8SC_ASSERT_NOW(a_ready_drain, m_tvalid && !m_tready, !s_tready, "input taken over stalled output")

endmodule

bind utf8_sanitizing_copy utf8sc_checker u_utf8sc_checker (.*);

// ----- test/tb_utf8_sanitizing_copy.sv -----
`timescale 1ns / 100ps

module tb_utf8_sanitizing_copy;
  import utf8sc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } src_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;
  logic             m_tlast;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  // stimulus and scoreboard
  src_beat_t src_bytes_q[$];
  out_beat_t expected_out_q[$];
  int        queued_cnt = 0;
  int        taken_cnt = 0;
  int        mismatch_cnt = 0;
  logic      src_taken = 1'b0;
  logic      calm = 1'b0;

  // predictor state
  logic [CAP_W-1:0] capacity;
  logic [20:0]      cp_acc;
  logic [2:0]       seq_len;
  logic [2:0]       seq_got;
  logic [CAP_W-1:0] written;
  logic             copy_stopped;

  utf8_sanitizing_copy u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_cnt++;
  endtask

  task automatic clear_string();
    cp_acc = '0;
    seq_len = '0;
    seq_got = '0;
    written = '0;
    copy_stopped = 1'b0;
  endtask

  task automatic push_out(input logic [7:0] data, input logic last);
    out_beat_t ob;
    ob.data = data;
    ob.last = last;
    expected_out_q.push_back(ob);
  endtask

  // works out the output bytes caused by one source byte
  task automatic sanitize_byte(input logic [7:0] b, input logic eos);
    logic [2:0]  len;
    logic [20:0] cp;
    int          room;
    logic        stop;
    stop = 1'b0;
    if (copy_stopped) begin
      if (eos) clear_string();
    end else begin
      if (seq_len == 0) begin
        if ((b & CONT_MARK) == 8'h00) len = 3'd1;
        else if ((b & LEAD2_MASK) == LEAD2_MARK) len = 3'd2;
        else if ((b & LEAD3_MASK) == LEAD3_MARK) len = 3'd3;
        else if ((b & LEAD4_MASK) == LEAD4_MARK) len = 3'd4;
        else len = 3'd0;
        if (len == 0) begin
          stop = 1'b1;
        end else begin
          seq_len = len;
          seq_got = 3'd1;
          case (len)
            3'd1: cp_acc = 21'(b);
            3'd2: cp_acc = 21'(b & LEAD2_BITS);
            3'd3: cp_acc = 21'(b & LEAD3_BITS);
            default: cp_acc = 21'(b & LEAD4_BITS);
          endcase
        end
      end else if ((b & CONT_MASK) != CONT_MARK) begin
        stop = 1'b1;
      end else begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        seq_got = seq_got + 3'd1;
      end

      if (!stop && seq_got >= seq_len) begin
        cp = cp_acc;
        room = (capacity > written) ? int'(capacity) - int'(written) : 0;
        if (cp == 0 || cp > MAX_CODEPOINT) begin
          stop = 1'b1;
        end else if (room <= int'(seq_len)) begin
          stop = 1'b1;
        end else begin
          // shortest form, so overlong input shrinks here
          if (cp < 21'h80) begin
            push_out(cp[7:0], 1'b0);
            written = written + CAP_W'(1);
          end else if (cp < 21'h800) begin
            push_out(LEAD2_MARK | {3'b0, cp[10:6]}, 1'b0);
            push_out(CONT_MARK | {2'b0, cp[5:0]}, 1'b0);
            written = written + CAP_W'(2);
          end else if (cp < 21'h10000) begin
            push_out(LEAD3_MARK | {4'b0, cp[15:12]}, 1'b0);
            push_out(CONT_MARK | {2'b0, cp[11:6]}, 1'b0);
            push_out(CONT_MARK | {2'b0, cp[5:0]}, 1'b0);
            written = written + CAP_W'(3);
          end else begin
            push_out(LEAD4_MARK | {5'b0, cp[20:18]}, 1'b0);
            push_out(CONT_MARK | {2'b0, cp[17:12]}, 1'b0);
            push_out(CONT_MARK | {2'b0, cp[11:6]}, 1'b0);
            push_out(CONT_MARK | {2'b0, cp[5:0]}, 1'b0);
            written = written + CAP_W'(4);
          end
          cp_acc = '0;
          seq_len = '0;
          seq_got = '0;
        end
      end

      // end of source either closes a full string or cuts a sequence off
      if (!stop && eos) stop = 1'b1;
      if (stop) begin
        push_out(8'h00, 1'b1);
        clear_string();
        copy_stopped = !eos;
      end
    end
  endtask

  // source side
  always @(negedge clk) begin
    src_beat_t sb;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || src_taken) begin
      if (src_bytes_q.size() != 0 && (calm || $urandom_range(99) >= 17)) begin
        sb = src_bytes_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= sb.data;
        s_tlast <= sb.eos;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // destination side
  always @(negedge clk) begin
    m_tready <= !rst && (calm || $urandom_range(99) >= 17);
  end

  // predictor and checker
  always @(posedge clk) begin
    out_beat_t ob;
    if (rst) begin
      capacity = CAP_RESET;
      clear_string();
      src_taken <= 1'b0;
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      src_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        taken_cnt++;
        sanitize_byte(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        if (expected_out_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat data %02h last %0b", m_tdata, m_tlast));
        end else begin
          ob = expected_out_q.pop_front();
          if (m_tdata !== ob.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", m_tdata, ob.data));
          if (m_tlast !== ob.last)
            report_mismatch($sformatf("is_last %0b, expected %0b", m_tlast, ob.last));
        end
      end
    end
  end

  task automatic queue_byte(input logic [7:0] data, input logic eos);
    src_beat_t sb;
    sb.data = data;
    sb.eos = eos;
    src_bytes_q.push_back(sb);
    queued_cnt++;
  endtask

  // first nbytes of a sequence of len bytes carrying cp, eos on the final one
  task automatic queue_char(input logic [20:0] cp, input int len, input int nbytes,
                            input logic eos);
    logic [7:0] b;
    int         sh;
    for (int k = 0; k < nbytes; k++) begin
      sh = 6 * (len - 1 - k);
      if (k > 0) begin
        b = CONT_MARK | (8'(cp >> sh) & LOW6_MASK);
      end else begin
        case (len)
          1: b = {1'b0, cp[6:0]};
          2: b = LEAD2_MARK | (8'(cp >> sh) & LEAD2_BITS);
          3: b = LEAD3_MARK | (8'(cp >> sh) & LEAD3_BITS);
          default: b = LEAD4_MARK | (8'(cp >> sh) & LEAD4_BITS);
        endcase
      end
      queue_byte(b, eos && k == nbytes - 1);
    end
  endtask

  function automatic logic [20:0] valid_cp(input int len);
    case (len)
      1: valid_cp = 21'($urandom_range(1, 'h7F));
      2: valid_cp = 21'($urandom_range('h80, 'h7FF));
      3: valid_cp = 21'($urandom_range('h800, 'hFFFF));
      default: valid_cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
  endfunction

  // mostly well formed text, with a few broken sequences mixed in
  task automatic queue_string();
    int   nchars;
    int   r;
    int   len;
    logic last;
    logic [7:0] bad;
    nchars = $urandom_range(1, 10);
    for (int i = 0; i < nchars; i++) begin
      r = $urandom_range(99);
      last = (i == nchars - 1);
      len = $urandom_range(2, 4);
      if (r < 70) begin
        len = $urandom_range(1, 4);
        queue_char(valid_cp(len), len, len, last);
      end else if (r < 76) begin
        queue_char(21'($urandom_range(0, 'h7F)), len, len, last);
      end else if (r < 80) begin
        queue_char(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4, last);
      end else if (r < 86) begin
        queue_byte(8'($urandom_range(255)), last);
      end else if (r < 90) begin
        queue_byte(8'h00, last);
      end else if (r < 94) begin
        // cut off by end of source
        queue_char(valid_cp(len), len, $urandom_range(1, len - 1), 1'b1);
        break;
      end else begin
        bad = ($urandom_range(1) == 1) ? 8'($urandom_range('hC0, 'hFF))
                                       : 8'($urandom_range(0, 'h7F));
        queue_char(valid_cp(len), len, $urandom_range(1, len - 1), 1'b0);
        queue_byte(bad, last);
      end
    end
  endtask

  // everything sent, everything received, then let the pipeline drain
  task automatic wait_idle();
    while (taken_cnt != queued_cnt || expected_out_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  logic [8:0] directed_seq[$] = '{
    // max of each length plus a surrogate, all copied
    9'h07F, 9'h0DF, 9'h0BF, 9'h0EF, 9'h0BF, 9'h0BF, 9'h0ED, 9'h0A0, 9'h080,
    9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,
    // null, then ignored bytes up to end of source
    9'h000, 9'h041, 9'h142,
    // overlong null
    9'h0C0, 9'h180,
    // bad leads
    9'h180, 9'h1F8,
    // bad continuation
    9'h0C3, 9'h141,
    // above the codepoint range
    9'h0F4, 9'h090, 9'h080, 9'h180,
    // cut off
    9'h0E2, 9'h182
  };

  initial begin
    logic [CAP_W-1:0] cap_pick;
    int               goal;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_seq[i]) queue_byte(directed_seq[i][7:0], directed_seq[i][8]);

    // no room at all: terminator only
    wait_idle();
    set_capacity('0);
    queue_byte(8'h41, 1'b1);

    // overlong pair shrinks to one byte, so the second still fails the fit test
    wait_idle();
    set_capacity(CAP_W'(3));
    queue_byte(8'hC1, 1'b0);
    queue_byte(8'h81, 1'b0);
    queue_byte(8'hC1, 1'b0);
    queue_byte(8'h81, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      if (ph == 0) cap_pick = '1;
      else if (ph == 1) cap_pick = CAP_W'(1);
      else if ($urandom_range(99) < 70) cap_pick = CAP_W'($urandom_range(2, 24));
      else cap_pick = CAP_W'($urandom_range(25, 65534));
      set_capacity(cap_pick);
      calm <= (ph == 3);
      goal = queued_cnt + 38;
      while (queued_cnt < goal) begin
        queue_string();
        while (src_bytes_q.size() > 16) @(posedge clk);
      end
    end

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/utf8sc_pkg.sv
sv/utf8sc_decode.sv
sv/utf8sc_emit.sv
sv/utf8_sanitizing_copy.sv
sv/utf8sc_checker.sv
test/tb_utf8_sanitizing_copy.sv
